[rtl/core/vfss_pkg.sv]
// shared types and constants of the frame size search unit
`timescale 1ns / 1ps
`default_nettype none

package vfss_pkg;

  localparam int unsigned MAX_W     = 16;
  localparam int unsigned BW_W      = 34;
  localparam int unsigned CHAN_W    = 11;
  localparam int unsigned SBITS_W   = 6;
  localparam int unsigned SS_RAW_W  = 17;  // channel_count * sample_bits
  localparam int unsigned SS_W      = 18;  // complete sample, doubled when complex
  localparam int unsigned RATE_W    = 52;  // channel_count * sample_bits * bandwidth * 2
  localparam int unsigned DIV_W     = 19;  // eight times a 16-bit frame size
  localparam int unsigned MUL_CNT_W = 5;
  localparam int unsigned MOD_CNT_W = 6;
  localparam int unsigned STAT_W    = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SMALL = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNSUP = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [MAX_W-1:0]   max_bytes;
    logic [BW_W-1:0]    bandwidth_hz;
    logic [CHAN_W-1:0]  channel_count;
    logic [SBITS_W-1:0] sample_bits;
    logic               complex_flag;
  } in_t;

  typedef struct packed {
    logic [MAX_W-1:0]  frame_bytes;
    logic [STAT_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic                start;
    logic [BW_W-1:0]     multiplicand;
    logic [SS_RAW_W-1:0] multiplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rate;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

[rtl/core/vfss_ser_mul.sv]
// bit-serial shift-add multiplier that forms the doubled bit rate
`timescale 1ns / 1ps
`default_nettype none

module vfss_ser_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vfss_pkg::mul_req_t req_i,
  output vfss_pkg::mul_rsp_t     rsp_o
);

  logic [vfss_pkg::RATE_W-2:0]    acc_q, acc_d;
  logic [vfss_pkg::RATE_W-2:0]    add_q, add_d;
  logic [vfss_pkg::SS_RAW_W-1:0]  m_q, m_d;
  logic [vfss_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                           done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    add_d  = add_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d = '0;
      add_d = (vfss_pkg::RATE_W-1)'(req_i.multiplicand);
      m_d   = req_i.multiplier;
      cnt_d = vfss_pkg::MUL_CNT_W'(vfss_pkg::SS_RAW_W);
    end else if (cnt_q != '0) begin
      // one multiplier bit per cycle, lsb first
      if (m_q[0]) begin
        acc_d = acc_q + add_q;
      end
      add_d  = add_q << 1;
      m_d    = m_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == vfss_pkg::MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      add_q  <= '0;
      m_q    <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      add_q  <= add_d;
      m_q    <= m_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rate = {acc_q, 1'b0};

endmodule

`default_nettype wire

[rtl/core/vfss_ser_mod.sv]
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module vfss_ser_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vfss_pkg::mod_req_t req_i,
  output vfss_pkg::mod_rsp_t     rsp_o
);

  logic [vfss_pkg::RATE_W-1:0]    div_q, div_d;
  logic [vfss_pkg::DIV_W-1:0]     dvs_q, dvs_d;
  logic [vfss_pkg::DIV_W-1:0]     rem_q, rem_d;
  logic [vfss_pkg::MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [vfss_pkg::DIV_W:0]       shifted;
  logic [vfss_pkg::DIV_W:0]       diff;
  logic                           ge;

  // remainder stays below the divisor, so the shifted value is below twice it
  assign shifted = {rem_q, div_q[vfss_pkg::RATE_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    div_d  = div_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      div_d = req_i.dividend;
      dvs_d = req_i.divisor;
      rem_d = '0;
      cnt_d = vfss_pkg::MOD_CNT_W'(vfss_pkg::RATE_W);
    end else if (cnt_q != '0) begin
      div_d  = div_q << 1;
      rem_d  = ge ? diff[vfss_pkg::DIV_W-1:0] : shifted[vfss_pkg::DIV_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == vfss_pkg::MOD_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      div_q  <= div_d;
      dvs_q  <= dvs_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/vdif_frame_size_search_unit.sv]
// frame size search: sample checks, serial rate multiply and countdown of candidates
// sequence: an early error goes straight to the result; otherwise a rate multiply, then
//   a limit remainder, then one serial remainder per candidate, up to 8191 candidates
// throughput: one request in flight; the next is taken while a result waits in the
//   output register
// reset: asynchronous active low, returns to idle with no result pending
`timescale 1ns / 1ps
`default_nettype none

module vdif_frame_size_search_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire vfss_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output vfss_pkg::out_t     out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RATE,
    S_SIZE,
    S_TEST,
    S_WAIT,
    S_DONE
  } state_e;

  state_e                        state_q;
  vfss_pkg::in_t                 in_q;
  logic [vfss_pkg::SS_RAW_W-1:0] raw_q;
  logic [vfss_pkg::SS_W-1:0]     ss_q;
  logic [vfss_pkg::MAX_W-1:0]    block_q;
  logic [vfss_pkg::MAX_W-1:0]    size_q;
  logic [vfss_pkg::RATE_W-1:0]   rate_q;
  vfss_pkg::out_t                res_q;
  vfss_pkg::out_t                out_q;
  logic                          out_valid_q;
  vfss_pkg::mul_req_t            mul_req_q;
  vfss_pkg::mul_rsp_t            mul_rsp;
  vfss_pkg::mod_req_t            mod_req_q;
  vfss_pkg::mod_rsp_t            mod_rsp;

  logic [vfss_pkg::SS_RAW_W-1:0] raw_in;
  logic [vfss_pkg::SS_W-1:0]     blk_w;
  logic                          unsup;
  logic                          chk_ok;
  logic                          mul_go;
  logic                          mod_go;

  assign raw_in = vfss_pkg::SS_RAW_W'(in_data_i.channel_count)
                * vfss_pkg::SS_RAW_W'(in_data_i.sample_bits);

  // sample block and support check
  always_comb begin
    blk_w = ss_q;
    unsup = 1'b0;
    if (ss_q == '0) begin
      unsup = 1'b1;
    end else if (ss_q < vfss_pkg::SS_W'(64)) begin
      // under 64 bits it must divide 64, i.e. be a power of two
      unsup = ($countones(ss_q[5:0]) != 1);
      blk_w = vfss_pkg::SS_W'(8);
    end else begin
      unsup = (ss_q[5:0] != '0);
    end
  end

  assign chk_ok = (in_q.max_bytes >= vfss_pkg::MAX_W'(8)) && !unsup
                && (vfss_pkg::SS_W'(in_q.max_bytes) >= blk_w);

  // one-cycle start pulses for the serial units
  assign mul_go = (state_q == S_CHECK) && chk_ok;
  assign mod_go = ((state_q == S_RATE) && mul_rsp.done)
                || ((state_q == S_TEST) && (size_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_q        <= '0;
      raw_q       <= '0;
      ss_q        <= '0;
      block_q     <= '0;
      size_q      <= '0;
      rate_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      mul_req_q   <= '0;
      mod_req_q   <= '0;
    end else begin
      mul_req_q.start <= mul_go;
      mod_req_q.start <= mod_go;
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            raw_q   <= raw_in;
            ss_q    <= in_data_i.complex_flag ? {raw_in, 1'b0} : {1'b0, raw_in};
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (in_q.max_bytes < vfss_pkg::MAX_W'(8)) begin
            res_q   <= '{frame_bytes: '0, status: vfss_pkg::ST_SMALL};
            state_q <= S_DONE;
          end else if (unsup) begin
            res_q   <= '{frame_bytes: '0, status: vfss_pkg::ST_UNSUP};
            state_q <= S_DONE;
          end else if (vfss_pkg::SS_W'(in_q.max_bytes) < blk_w) begin
            res_q   <= '{frame_bytes: '0, status: vfss_pkg::ST_SMALL};
            state_q <= S_DONE;
          end else begin
            block_q                <= blk_w[vfss_pkg::MAX_W-1:0];
            mul_req_q.multiplicand <= in_q.bandwidth_hz;
            mul_req_q.multiplier   <= raw_q;
            state_q                <= S_RATE;
          end
        end
        S_RATE: begin
          if (mul_rsp.done) begin
            rate_q             <= mul_rsp.rate;
            // first candidate: limit rounded down to a block multiple
            mod_req_q.dividend <= vfss_pkg::RATE_W'(in_q.max_bytes);
            mod_req_q.divisor  <= vfss_pkg::DIV_W'(block_q);
            state_q            <= S_SIZE;
          end
        end
        S_SIZE: begin
          if (mod_rsp.done) begin
            size_q  <= in_q.max_bytes - mod_rsp.rem[vfss_pkg::MAX_W-1:0];
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          if (size_q == '0) begin
            res_q   <= '{frame_bytes: '0, status: vfss_pkg::ST_NONE};
            state_q <= S_DONE;
          end else begin
            mod_req_q.dividend <= rate_q;
            mod_req_q.divisor  <= {size_q, 3'b000};
            state_q            <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mod_rsp.done) begin
            if (mod_rsp.rem == '0) begin
              res_q   <= '{frame_bytes: size_q, status: vfss_pkg::ST_OK};
              state_q <= S_DONE;
            end else begin
              size_q  <= size_q - block_q;
              state_q <= S_TEST;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  vfss_ser_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .rsp_o  (mul_rsp)
  );

  vfss_ser_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req_q),
    .rsp_o  (mod_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
